// ===== rtl/ssa_pkg.sv =====
package ssa_pkg;

    typedef logic [5:0] t_slab_num;
    typedef logic [4:0] t_slot_num;
    typedef logic [1:0] t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_REJECTED  = 2'd2;

endpackage

// ===== rtl/slab_slot_allocator_unit.sv =====
// a return is checked and written in S_RD; an allocate from a slab with free slots goes
// through S_RD, S_POP and S_POPW, and a new slab is first filled slot by slot in S_FILL;
// one word at a time: start is taken only while busy is low;
// when a slab empties, busy stays high while the later slabs are checked for free slots;
// the result strobe lasts one cycle and the receiver cannot stall
// i_rst_n is synchronous and active low, it empties the pool; count and stack memories are not cleared
module slab_slot_allocator_unit #(
    parameter int SLABS_MAX      = 64,
    parameter int SLOTS_PER_SLAB = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  ssa_pkg::t_slab_num i_slab_number,
    input  ssa_pkg::t_slot_num i_slot_number,
    output logic               o_valid,
    output ssa_pkg::t_slab_num o_granted_slab,
    output ssa_pkg::t_slot_num o_granted_slot,
    output ssa_pkg::t_status   o_status
);
    import ssa_pkg::*;

    localparam int SW    = (SLABS_MAX > 1) ? $clog2(SLABS_MAX) : 1;
    localparam int UW    = $clog2(SLABS_MAX + 1);
    localparam int IW    = $clog2(SLOTS_PER_SLAB);
    localparam int CW    = $clog2(SLOTS_PER_SLAB + 1);
    localparam int DEPTH = SLABS_MAX * SLOTS_PER_SLAB;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RD       = 7'b0000010,
        S_FILL     = 7'b0000100,
        S_POP      = 7'b0001000,
        S_POPW     = 7'b0010000,
        S_SCAN_RD  = 7'b0100000,
        S_SCAN_CHK = 7'b1000000
    } t_state;

    logic [CW-1:0] cnt_mem [SLABS_MAX];
    logic [IW-1:0] stk_mem [DEPTH];

    t_state      r_state, n_state;
    logic        r_action, n_action;
    t_slab_num   r_slab_in, n_slab_in;
    t_slot_num   r_slot_in, n_slot_in;
    logic [SW-1:0] r_slab, n_slab;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_fill, n_fill;
    logic [UW-1:0] r_j, n_j;
    logic [UW-1:0] r_used, n_used;
    logic [SW-1:0] r_hint, n_hint;
    logic        r_hint_valid, n_hint_valid;
    logic        r_valid, n_valid;
    t_slab_num   r_gslab, n_gslab;
    t_slot_num   r_gslot, n_gslot;
    t_status     r_status, n_status;

    logic [CW-1:0] r_cnt_rd;
    logic [IW-1:0] r_stk_rd;

    logic [SW-1:0] cnt_raddr;
    logic          cnt_we;
    logic [SW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic [AW-1:0] stk_raddr;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [IW-1:0] stk_wdata;
    logic [AW-1:0] slab_base;
    logic          reject;
    logic          need_new;

    assign slab_base = AW'(AW'(r_slab) * AW'(SLOTS_PER_SLAB));
    assign stk_raddr = AW'(slab_base + AW'(r_cnt - CW'(1)));

    assign reject = (32'(r_slab_in) >= 32'(r_used)) || (32'(r_slab_in) >= 32'(SLABS_MAX))
                 || (32'(r_slot_in) >= 32'(SLOTS_PER_SLAB))
                 || (32'(r_cnt_rd) >= 32'(SLOTS_PER_SLAB));
    assign need_new = !r_hint_valid || (UW'(r_hint) >= r_used) || (r_cnt_rd == '0);

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_slab_in    = r_slab_in;
        n_slot_in    = r_slot_in;
        n_slab       = r_slab;
        n_cnt        = r_cnt;
        n_fill       = r_fill;
        n_j          = r_j;
        n_used       = r_used;
        n_hint       = r_hint;
        n_hint_valid = r_hint_valid;
        n_valid      = 1'b0;
        n_gslab      = r_gslab;
        n_gslot      = r_gslot;
        n_status     = r_status;
        cnt_raddr    = r_hint;
        cnt_we       = 1'b0;
        cnt_waddr    = r_slab;
        cnt_wdata    = r_cnt;
        stk_we       = 1'b0;
        stk_waddr    = AW'(slab_base + AW'(r_fill));
        stk_wdata    = IW'(SLOTS_PER_SLAB - 1) - r_fill;

        case (r_state)
            S_IDLE: begin
                if (i_action == ACT_FREE) begin
                    cnt_raddr = SW'(i_slab_number);
                end
                if (start) begin
                    n_action  = i_action;
                    n_slab_in = i_slab_number;
                    n_slot_in = i_slot_number;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                if (r_action == ACT_FREE) begin
                    n_valid = 1'b1;
                    n_gslab = '0;
                    n_gslot = '0;
                    n_state = S_IDLE;
                    if (reject) begin
                        n_status = ST_REJECTED;
                    end else begin
                        n_status  = ST_OK;
                        cnt_we    = 1'b1;
                        cnt_waddr = SW'(r_slab_in);
                        cnt_wdata = r_cnt_rd + CW'(1);
                        stk_we    = 1'b1;
                        stk_waddr = AW'(AW'(SW'(r_slab_in)) * AW'(SLOTS_PER_SLAB)
                                        + AW'(r_cnt_rd));
                        stk_wdata = IW'(r_slot_in);
                        if (!r_hint_valid || (SW'(r_slab_in) < r_hint)) begin
                            n_hint       = SW'(r_slab_in);
                            n_hint_valid = 1'b1;
                        end
                    end
                end else if (need_new) begin
                    if (32'(r_used) >= 32'(SLABS_MAX)) begin
                        n_valid  = 1'b1;
                        n_gslab  = '0;
                        n_gslot  = '0;
                        n_status = ST_EXHAUSTED;
                        n_state  = S_IDLE;
                    end else begin
                        n_slab       = SW'(r_used);
                        n_hint       = SW'(r_used);
                        n_hint_valid = 1'b1;
                        n_used       = r_used + UW'(1);
                        n_fill       = '0;
                        n_state      = S_FILL;
                    end
                end else begin
                    n_slab  = r_hint;
                    n_cnt   = r_cnt_rd;
                    n_state = S_POP;
                end
            end
            S_FILL: begin
                stk_we = 1'b1;
                if (r_fill == IW'(SLOTS_PER_SLAB - 1)) begin
                    n_cnt   = CW'(SLOTS_PER_SLAB);
                    n_state = S_POP;
                end else begin
                    n_fill = r_fill + IW'(1);
                end
            end
            S_POP: begin
                cnt_we    = 1'b1;
                cnt_wdata = r_cnt - CW'(1);
                n_cnt     = r_cnt - CW'(1);
                n_state   = S_POPW;
            end
            S_POPW: begin
                n_valid  = 1'b1;
                n_gslab  = 6'(r_slab);
                n_gslot  = 5'(r_stk_rd);
                n_status = ST_OK;
                if (r_cnt == '0) begin
                    n_hint_valid = 1'b0;
                    n_hint       = '0;
                    n_j          = UW'(r_slab) + UW'(1);
                    n_state      = S_SCAN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                cnt_raddr = SW'(r_j);
                if (r_j >= r_used) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (r_cnt_rd != '0) begin
                    n_hint       = SW'(r_j);
                    n_hint_valid = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_j     = r_j + UW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_hint       <= '0;
            r_hint_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_hint       <= n_hint;
            r_hint_valid <= n_hint_valid;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_slab_in <= n_slab_in;
        r_slot_in <= n_slot_in;
        r_slab    <= n_slab;
        r_cnt     <= n_cnt;
        r_fill    <= n_fill;
        r_j       <= n_j;
        r_gslab   <= n_gslab;
        r_gslot   <= n_gslot;
        r_status  <= n_status;
    end

    // free count memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= cnt_mem[cnt_raddr];
    end

    // free slot stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= stk_mem[stk_raddr];
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_granted_slab = r_gslab;
    assign o_granted_slot = r_gslot;
    assign o_status       = r_status;

endmodule

// ===== rtl/ssa_checker.sv =====
module ssa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_action,
    input ssa_pkg::t_slab_num i_slab_number,
    input ssa_pkg::t_slot_num i_slot_number,
    input logic               o_valid,
    input ssa_pkg::t_slab_num o_granted_slab,
    input ssa_pkg::t_slot_num o_granted_slot,
    input ssa_pkg::t_status   o_status
);
    import ssa_pkg::*;

    // accepted word keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // a result only follows work in progress
    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a word in progress");

    // one word at a time, so strobes never touch
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result strobes in a row");

    // no grant unless status is ok
    a_zero_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_granted_slab == '0) && (o_granted_slot == '0))
        else $error("grant fields set on a failed word");

endmodule

bind slab_slot_allocator_unit ssa_checker u_ssa_checker (.*);
